/* hdl/bpt_pkg.sv */
// Package with widths, register codes and reset values of the blind position tracker.
`timescale 1ns / 1ps

package bpt_pkg;

  localparam int unsigned CNT_W     = 13;
  localparam int unsigned PCT_W     = 8;
  localparam int unsigned COVER_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_MARK      = 2'd0,
    CFG_BOTTOM_MARK   = 2'd1,
    CFG_TOP_OVERTRAV  = 2'd2,
    CFG_BOTTOM_OVERTR = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_COVER = 1'b1
  } cmd_e;

  localparam logic [CNT_W-1:0] TOP_MARK_RST      = 13'd500;
  localparam logic [CNT_W-1:0] BOTTOM_MARK_RST   = 13'd4650;
  localparam logic [CNT_W-1:0] TOP_OVERTRAV_RST  = 13'd200;
  localparam logic [CNT_W-1:0] BOTTOM_OVERTR_RST = 13'd4950;

  localparam logic [PCT_W-1:0] PCT_LIMIT = 8'd101;
  localparam logic [PCT_W-1:0] PCT_FULL  = 8'd100;
  localparam logic [PCT_W-1:0] PCT_OPEN  = 8'd0;

  // Floor division by 100 of a signed product: the product is lifted by
  // 100 * 8192 so that it is never negative, then divided by a reciprocal.
  localparam int unsigned PROD_W   = 23;
  localparam int unsigned BIASED_W = 21;
  localparam int unsigned RECIP_W  = 22;
  localparam int unsigned RECIP_SH = 28;
  localparam int unsigned QUOT_W   = 14;
  localparam int unsigned GOAL_S_W = 16;

  localparam logic signed [PROD_W-1:0]   DIV_BIAS  = 23'sd819200;
  localparam logic [RECIP_W-1:0]         RECIP_M   = 22'd2684355;
  localparam logic signed [GOAL_S_W-1:0] QUOT_BIAS = 16'sd8192;

endpackage

/* hdl/bpt_if.sv */
// Valid/ready channel interfaces of the blind position tracker.
`timescale 1ns / 1ps

interface bpt_cmd_if import bpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [PCT_W-1:0] cover_request;

  modport source (output valid, command, cover_request, input ready);
  modport sink   (input valid, command, cover_request, output ready);
endinterface

interface bpt_res_if import bpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             motor_on;
  logic             moving_up;
  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] goal_position;
  logic             request_taken;

  modport source (output valid, motor_on, moving_up, position, goal_position, request_taken,
                  input ready);
  modport sink   (input valid, motor_on, moving_up, position, goal_position, request_taken,
                  output ready);
endinterface

interface bpt_cfg_if import bpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/blind_position_tracker.sv */
// Top level of the blind position tracker: goal pipeline and motor state update.
`timescale 1ns / 1ps

// The tracker takes one tick or cover request per cycle while the result channel
// does not stall, and returns one result for each. An item passes an input register,
// a stage that forms percent times span, a stage that divides by 100 through a
// constant reciprocal multiplier and adds the top mark, and the motor state update,
// whose result lands in the output register. The two multipliers of the goal path
// set the depth; the state update itself is a single step, so the sustained rate is
// one item per cycle while the result channel does not stall. Configuration writes
// are always ready and must only be issued while no item is in flight.

module blind_position_tracker import bpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpt_cmd_if.sink    cmd_i,
  bpt_res_if.source  res_o,
  bpt_cfg_if.sink    cfg_i
);

  logic [CNT_W-1:0] top_mark_q, bottom_mark_q, top_ot_q, bottom_ot_q;

  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   goal_q, goal_d;
  logic               dir_up_q, dir_up_d;
  logic               run_q, run_d;
  logic [COVER_W-1:0] cover_q, cover_d;
  logic               taken_q, taken_d;

  logic s1_vq, s2_vq, s3_vq, out_vq;
  logic out_free, s3_free, s2_free, s1_free, s3_go;

  cmd_e             s1_cmd_q, s2_cmd_q, s3_cmd_q;
  logic [PCT_W-1:0] s1_pct_q, s2_pct_q, s3_pct_q;
  logic [BIASED_W-1:0] s2_biased_q;
  logic [CNT_W-1:0]    s3_mid_q;

  logic signed [CNT_W:0]           span;
  logic signed [PROD_W-1:0]        prod;
  logic signed [PROD_W-1:0]        biased;
  logic [BIASED_W+RECIP_W-1:0]     recip_prod;
  logic [QUOT_W-1:0]               quot;
  logic signed [GOAL_S_W-1:0]      mid_s;
  logic [CNT_W-1:0]                mid_d;

  logic [CNT_W-1:0] pos_dec, pos_inc, req_goal;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_mark_q    <= TOP_MARK_RST;
      bottom_mark_q <= BOTTOM_MARK_RST;
      top_ot_q      <= TOP_OVERTRAV_RST;
      bottom_ot_q   <= BOTTOM_OVERTR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_TOP_MARK:      top_mark_q    <= cfg_i.data;
        CFG_BOTTOM_MARK:   bottom_mark_q <= cfg_i.data;
        CFG_TOP_OVERTRAV:  top_ot_q      <= cfg_i.data;
        CFG_BOTTOM_OVERTR: bottom_ot_q   <= cfg_i.data;
        default:           top_mark_q    <= top_mark_q;
      endcase
    end
  end

  assign out_free    = !out_vq || res_o.ready;
  assign s3_free     = !s3_vq || out_free;
  assign s2_free     = !s2_vq || s3_free;
  assign s1_free     = !s1_vq || s2_free;
  assign s3_go       = s3_vq && out_free;
  assign cmd_i.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq  <= 1'b0;
      s2_vq  <= 1'b0;
      s3_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      if (s1_free)  s1_vq  <= cmd_i.valid;
      if (s2_free)  s2_vq  <= s1_vq;
      if (s3_free)  s3_vq  <= s2_vq;
      if (out_free) out_vq <= s3_vq;
    end
  end

  // Percent times span, lifted so that the floor division works on unsigned values.
  always_comb begin
    span   = $signed({1'b0, bottom_mark_q}) - $signed({1'b0, top_mark_q});
    prod   = $signed({{(PROD_W-PCT_W){1'b0}}, s1_pct_q}) * PROD_W'(span);
    biased = prod + DIV_BIAS;
  end

  always_comb begin
    recip_prod = s2_biased_q * RECIP_M;
    quot       = recip_prod[RECIP_SH +: QUOT_W];
    mid_s      = $signed({{(GOAL_S_W-CNT_W){1'b0}}, top_mark_q})
               + $signed({{(GOAL_S_W-QUOT_W){1'b0}}, quot}) - QUOT_BIAS;
    if (mid_s < 0) begin
      mid_d = '0;
    end else if (mid_s > $signed({{(GOAL_S_W-CNT_W){1'b0}}, CNT_MAX})) begin
      mid_d = CNT_MAX;
    end else begin
      mid_d = mid_s[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_cmd_q <= cmd_e'(cmd_i.command);
      s1_pct_q <= cmd_i.cover_request;
    end
    if (s2_free) begin
      s2_cmd_q    <= s1_cmd_q;
      s2_pct_q    <= s1_pct_q;
      s2_biased_q <= biased[BIASED_W-1:0];
    end
    if (s3_free) begin
      s3_cmd_q <= s2_cmd_q;
      s3_pct_q <= s2_pct_q;
      s3_mid_q <= mid_d;
    end
  end

  always_comb begin
    pos_dec  = (pos_q != '0) ? pos_q - CNT_W'(1) : pos_q;
    pos_inc  = (pos_q != CNT_MAX) ? pos_q + CNT_W'(1) : pos_q;
    req_goal = s3_mid_q;
    if (s3_pct_q == PCT_OPEN) begin
      req_goal = top_ot_q;
    end else if (s3_pct_q == PCT_FULL) begin
      req_goal = bottom_ot_q;
    end

    pos_d    = pos_q;
    goal_d   = goal_q;
    dir_up_d = dir_up_q;
    run_d    = run_q;
    cover_d  = cover_q;
    taken_d  = 1'b0;

    unique case (s3_cmd_q)
      CMD_COVER: begin
        if (s3_pct_q < PCT_LIMIT && s3_pct_q != {1'b0, cover_q}) begin
          taken_d = 1'b1;
          cover_d = s3_pct_q[COVER_W-1:0];
          goal_d  = req_goal;
          if (req_goal != pos_q) begin
            dir_up_d = req_goal < pos_q;
            run_d    = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (run_q) begin
          if (dir_up_q) begin
            pos_d = pos_dec;
            if (pos_dec <= goal_q || pos_dec < top_ot_q) begin
              run_d = 1'b0;
              if (pos_dec <= top_ot_q) begin
                pos_d = top_mark_q;
              end
            end
          end else begin
            pos_d = pos_inc;
            if (pos_inc >= goal_q || pos_inc > bottom_ot_q) begin
              run_d = 1'b0;
              if (pos_inc >= bottom_ot_q) begin
                pos_d = bottom_mark_q;
              end
            end
          end
        end
      end
      default: taken_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= BOTTOM_MARK_RST;
      goal_q   <= TOP_OVERTRAV_RST;
      dir_up_q <= 1'b1;
      run_q    <= 1'b1;
      cover_q  <= '0;
      taken_q  <= 1'b0;
    end else if (s3_go) begin
      pos_q    <= pos_d;
      goal_q   <= goal_d;
      dir_up_q <= dir_up_d;
      run_q    <= run_d;
      cover_q  <= cover_d;
      taken_q  <= taken_d;
    end
  end

  // The state registers load only together with the output register, so they
  // double as the result payload.
  assign res_o.valid         = out_vq;
  assign res_o.motor_on      = run_q;
  assign res_o.moving_up     = dir_up_q;
  assign res_o.position      = pos_q;
  assign res_o.goal_position = goal_q;
  assign res_o.request_taken = taken_q;

endmodule

/* hdl/bpt_checker.sv */
// Port-level checks of the blind position tracker and their binding.
`timescale 1ns / 1ps

module bpt_checker import bpt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             motor_on_i,
  input logic [CNT_W-1:0] position_i,
  input logic [CNT_W-1:0] goal_position_i,
  input logic             request_taken_i
);

  logic idle_cycle;

  assign idle_cycle = !(in_valid_i && in_ready_i) && out_ready_i;

  // A request that moves the goal away from the position must start the motor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && request_taken_i && (goal_position_i != position_i) |-> motor_on_i)
    else $error("Taken request left the motor off with the goal away from the position.");

  // With no new transfer in and a ready sink, the pipeline drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_cycle ##1 idle_cycle ##1 idle_cycle ##1 idle_cycle |=> !out_valid_i)
    else $error("Result appeared without a matching input transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result withdrawn before its transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(position_i) && $stable(goal_position_i))
    else $error("Stalled result changed.");

endmodule

bind blind_position_tracker bpt_checker u_bpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (cmd_i.valid),
  .in_ready_i      (cmd_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .motor_on_i      (res_o.motor_on),
  .position_i      (res_o.position),
  .goal_position_i (res_o.goal_position),
  .request_taken_i (res_o.request_taken)
);

/* tb/tb_top.sv */
// Self-checking testbench of the blind position tracker with random and directed items.
`timescale 1ns / 1ps

module tb_top;
  import bpt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned MAX_WAIT    = 12;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int          COUNT_TOP   = 8191;

  typedef struct packed {
    cmd_e             command;
    logic [PCT_W-1:0] percent;
  } blind_cmd_t;

  typedef struct packed {
    logic             motor_on;
    logic             moving_up;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] goal;
    logic             taken;
  } blind_report_t;

  logic clk_i;
  logic rst_ni;

  bpt_cmd_if cmd_if ();
  bpt_res_if res_if ();
  bpt_cfg_if cfg_if ();

  blind_position_tracker i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  logic [CNT_W-1:0]   mark_top     = TOP_MARK_RST;
  logic [CNT_W-1:0]   mark_bottom  = BOTTOM_MARK_RST;
  logic [CNT_W-1:0]   limit_top    = TOP_OVERTRAV_RST;
  logic [CNT_W-1:0]   limit_bottom = BOTTOM_OVERTR_RST;

  logic [CNT_W-1:0]   blind_pos;
  logic [CNT_W-1:0]   blind_goal;
  logic               blind_up;
  logic               blind_running;
  logic [COVER_W-1:0] blind_cover;

  blind_cmd_t    queued_commands[$];
  blind_report_t awaited_reports[$];

  bit            tx_no_idle;
  bit            rx_no_stall;
  int unsigned   rx_hold_req;
  int unsigned   tx_wait;
  int unsigned   rx_wait;
  int unsigned   rx_hold;
  int unsigned   rx_hold_seen;
  blind_cmd_t    tx_item;
  blind_report_t rx_want;

  int unsigned error_count;
  int unsigned commands_accepted;
  int unsigned reports_checked;
  int unsigned requests_taken;
  int unsigned settings_applied;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [CNT_W-1:0] fit_count(input int value);
    if (value < 0) return '0;
    if (value > COUNT_TOP) return CNT_MAX;
    return value[CNT_W-1:0];
  endfunction

  // Goal for a cover percent; the middle range floors toward minus infinity.
  function automatic logic [CNT_W-1:0] cover_goal(input logic [PCT_W-1:0] pct);
    int span;
    int prod;
    int quot;
    if (pct == PCT_OPEN) return limit_top;
    if (pct == PCT_FULL) return limit_bottom;
    span = int'(mark_bottom) - int'(mark_top);
    prod = int'(pct) * span;
    quot = prod / 100;
    if (prod % 100 != 0 && prod < 0) quot = quot - 1;
    return fit_count(int'(mark_top) + quot);
  endfunction

  function automatic blind_report_t step_blind(input blind_cmd_t item);
    blind_report_t rep;
    rep.taken = 1'b0;
    if (item.command == CMD_COVER) begin
      if (item.percent < PCT_LIMIT && item.percent != {1'b0, blind_cover}) begin
        blind_cover = item.percent[COVER_W-1:0];
        blind_goal  = cover_goal(item.percent);
        if (blind_goal != blind_pos) begin
          blind_up      = blind_goal < blind_pos;
          blind_running = 1'b1;
        end
        rep.taken = 1'b1;
      end
    end else if (blind_running) begin
      if (blind_up) begin
        if (blind_pos != '0) blind_pos = blind_pos - CNT_W'(1);
        if (blind_pos <= blind_goal || blind_pos < limit_top) begin
          blind_running = 1'b0;
          if (blind_pos <= limit_top) blind_pos = mark_top;
        end
      end else begin
        if (blind_pos != CNT_MAX) blind_pos = blind_pos + CNT_W'(1);
        if (blind_pos >= blind_goal || blind_pos > limit_bottom) begin
          blind_running = 1'b0;
          if (blind_pos >= limit_bottom) blind_pos = mark_bottom;
        end
      end
    end
    rep.motor_on  = blind_running;
    rep.moving_up = blind_up;
    rep.position  = blind_pos;
    rep.goal      = blind_goal;
    return rep;
  endfunction

  task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid  <= 1'b0;
      tx_wait       = 0;
      blind_pos     = BOTTOM_MARK_RST;
      blind_goal    = TOP_OVERTRAV_RST;
      blind_up      = 1'b1;
      blind_running = 1'b1;
      blind_cover   = '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        awaited_reports.push_back(step_blind(tx_item));
        commands_accepted++;
        if (awaited_reports[$].taken) requests_taken++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          cmd_if.valid <= 1'b0;
        end else if (queued_commands.size() != 0) begin
          tx_item = queued_commands.pop_front();
          cmd_if.valid         <= 1'b1;
          cmd_if.command       <= tx_item.command;
          cmd_if.cover_request <= tx_item.percent;
          tx_wait = tx_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_wait      = 0;
      rx_hold      = 0;
      rx_hold_seen = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t ns: result with no expectation: motor %0b up %0b position %0d goal %0d",
                   $time, res_if.motor_on, res_if.moving_up, res_if.position,
                   res_if.goal_position);
          error_count++;
        end else begin
          rx_want = awaited_reports.pop_front();
          check_field("motor_on", CNT_W'(rx_want.motor_on), CNT_W'(res_if.motor_on));
          check_field("moving_up", CNT_W'(rx_want.moving_up), CNT_W'(res_if.moving_up));
          check_field("position", rx_want.position, res_if.position);
          check_field("goal_position", rx_want.goal, res_if.goal_position);
          check_field("request_taken", CNT_W'(rx_want.taken), CNT_W'(res_if.request_taken));
          reports_checked++;
        end
        rx_wait = rx_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (rx_hold_seen != rx_hold_req) begin
        rx_hold_seen = rx_hold_req;
        rx_hold      = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        res_if.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
               awaited_reports.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (queued_commands.size() != 0 || cmd_if.valid || awaited_reports.size() != 0);
  endtask

  task automatic write_marks(input logic [CNT_W-1:0] top, input logic [CNT_W-1:0] bottom,
                             input logic [CNT_W-1:0] top_ot, input logic [CNT_W-1:0] bottom_ot);
    cfg_reg_e         order[4] = '{CFG_TOP_MARK, CFG_BOTTOM_MARK, CFG_TOP_OVERTRAV,
                                   CFG_BOTTOM_OVERTR};
    logic [CNT_W-1:0] vals[4];
    vals = '{top, bottom, top_ot, bottom_ot};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk_i);
      while (!cfg_if.ready);
      case (order[i])
        CFG_TOP_MARK:      mark_top     = vals[i];
        CFG_BOTTOM_MARK:   mark_bottom  = vals[i];
        CFG_TOP_OVERTRAV:  limit_top    = vals[i];
        CFG_BOTTOM_OVERTR: limit_bottom = vals[i];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic queue_cover(input logic [PCT_W-1:0] pct);
    blind_cmd_t item;
    item.command = CMD_COVER;
    item.percent = pct;
    queued_commands.push_back(item);
  endtask

  task automatic queue_ticks(input int unsigned count);
    blind_cmd_t item;
    item.command = CMD_TICK;
    repeat (count) begin
      item.percent = PCT_W'($urandom_range(0, 255));
      queued_commands.push_back(item);
    end
  endtask

  // Mostly a request followed by a run of ticks; the rest are out-of-range covers, repeated covers and single ticks.
  task automatic queue_motion(input int unsigned count, input int unsigned tick_limit);
    int unsigned      added;
    int unsigned      pick;
    int unsigned      ticks;
    logic [PCT_W-1:0] last_pct;
    added    = 0;
    last_pct = PCT_OPEN;
    while (added < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        last_pct = PCT_W'($urandom_range(0, PCT_FULL));
        ticks    = $urandom_range(0, tick_limit);
        queue_cover(last_pct);
        queue_ticks(ticks);
        added += 1 + ticks;
      end else if (pick == 7) begin
        queue_cover(PCT_W'($urandom_range(PCT_LIMIT, 255)));
      end else if (pick == 8) begin
        queue_cover(last_pct);
      end else begin
        queue_ticks(1);
        added++;
      end
    end
  endtask

  // Places a small travel range near the current position, now and then in swapped order.
  task automatic setup_region();
    int               base;
    logic [CNT_W-1:0] top;
    logic [CNT_W-1:0] bottom;
    logic [CNT_W-1:0] top_ot;
    logic [CNT_W-1:0] bottom_ot;
    base      = int'(blind_pos) - int'($urandom_range(0, 30));
    top_ot    = fit_count(base);
    top       = fit_count(int'(top_ot) + int'($urandom_range(0, 6)));
    bottom    = fit_count(int'(top) + int'($urandom_range(0, 30)));
    bottom_ot = fit_count(int'(bottom) + int'($urandom_range(0, 6)));
    if ($urandom_range(0, 3) == 0) write_marks(bottom, top, top_ot, bottom_ot);
    else write_marks(top, bottom, top_ot, bottom_ot);
  endtask

  initial begin
    rst_ni               = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.command       = CMD_TICK;
    cmd_if.cover_request = '0;
    res_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_TOP_MARK;
    cfg_if.data          = '0;
    tx_no_idle           = 1'b0;
    rx_no_stall          = 1'b0;
    rx_hold_req          = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: the blind starts running up, and a cover of 0 repeats the stored cover.
    queue_ticks(1);
    queue_cover(8'd255);
    queue_cover(PCT_LIMIT);
    queue_cover(PCT_OPEN);
    queue_cover(PCT_FULL);
    queue_ticks(1);
    queue_cover(8'd50);
    queue_cover(8'd1);
    queue_cover(8'd99);
    queue_ticks(1);
    queue_cover(8'd170);
    queue_cover(8'd85);
    wait_idle();

    // A down move past the bottom limit stops at once and snaps to the bottom mark.
    write_marks(13'd8000, 13'd8100, 13'd7990, 13'd0);
    queue_cover(8'd50);
    queue_ticks(1);
    wait_idle();

    // Goal equal to position, stopped and then while moving, and an over-travel snap to the top.
    write_marks(13'd8099, 13'd8109, 13'd8097, 13'd8112);
    queue_cover(8'd10);
    queue_ticks(1);
    queue_cover(PCT_OPEN);
    queue_ticks(3);
    queue_cover(PCT_FULL);
    queue_ticks(1);
    queue_cover(8'd10);
    queue_ticks(1);

    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      tx_no_idle  = $urandom_range(0, 3) == 0;
      rx_no_stall = $urandom_range(0, 3) == 0;
      case (phase)
        2: begin
          write_marks('0, '0, '0, '0);
          queue_motion(15, 6);
        end
        4: begin
          write_marks(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
          queue_motion(15, 6);
        end
        6: begin
          write_marks('0, CNT_MAX, '0, CNT_MAX);
          queue_motion(15, 6);
        end
        8: begin
          write_marks(CNT_MAX, '0, CNT_MAX, '0);
          queue_motion(15, 6);
        end
        10: begin
          setup_region();
          tx_no_idle  = 1'b1;
          rx_no_stall = 1'b1;
          rx_hold_req++;
          queue_motion(80, 48);
        end
        11: begin
          setup_region();
          queue_motion(30, 48);
          wait_idle();
          queue_motion(30, 48);
        end
        default: begin
          setup_region();
          queue_motion(45, 48);
        end
      endcase
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (awaited_reports.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, awaited_reports.size());
      error_count += awaited_reports.size();
    end
    $display("Accepted %0d ticks and cover requests, checked %0d results,", commands_accepted,
             reports_checked);
    $display("%0d requests moved the goal; %0d register settings with extreme and swapped marks.",
             requests_taken, settings_applied);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bpt_pkg.sv
hdl/bpt_if.sv
hdl/blind_position_tracker.sv
hdl/bpt_checker.sv
tb/tb_top.sv
